// ===== hw/rtl/anagram_window_search_unit_defines.svh =====
// Assertion macros shared by the anagram window search unit.
`ifndef ANAGRAM_WINDOW_SEARCH_UNIT_DEFINES_SVH
`define ANAGRAM_WINDOW_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AWSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AWSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/awsu_pkg.sv =====
// Package with the constants, request codes and types of the anagram window search unit.
package awsu_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int PTR_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CNT_W       = LEN_W + 1;
    localparam int CODE_W      = 8;
    localparam int TBL_DEPTH   = 1 << CODE_W;
    localparam int NZ_W        = CODE_W + 1;
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [1:0] REQ_PATTERN = 2'd0;
    localparam logic [1:0] REQ_TEXT    = 2'd1;
    localparam logic [1:0] REQ_FINISH  = 2'd2;

    typedef struct packed {
        logic              is_report;
        logic [CODE_W-1:0] code;
        logic              dec;
        logic              check;
        logic              rep_ovf;
        logic              rep_empty;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== hw/rtl/awsu_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module awsu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/awsu_front.sv =====
// Front end: accepts requests, keeps the window ring and turns each request into table operations.
module awsu_front import awsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_req_type,
    input  logic [CODE_W-1:0] i_char_code,
    output logic              o_op_push,
    output t_op               o_op,
    input  t_qstat            i_qstat
);

    logic              r_pend;
    t_op               r_pend_op;
    logic [LEN_W-1:0]  r_plen;
    logic [PTR_W-1:0]  r_ptr;
    logic [LEN_W-1:0]  r_seen;
    logic              r_ovf;
    logic              r_started;
    logic [CODE_W-1:0] r_ring [PATTERN_MAX];

    logic              n_pend;
    t_op               n_pend_op;
    logic [LEN_W-1:0]  n_plen;
    logic [PTR_W-1:0]  n_ptr;
    logic [LEN_W-1:0]  n_seen;
    logic              n_ovf;
    logic              n_started;

    logic              accept;
    logic              ring_we;
    logic [PTR_W-1:0]  slot;
    logic [LEN_W-1:0]  slot_inc;
    logic [LEN_W-1:0]  seen_new;
    logic              win_full;
    t_op               enter_op;

    assign o_full = r_pend || i_qstat.full;
    assign accept = i_push && !o_full;

    always_comb begin
        slot     = (LEN_W'(r_ptr) >= r_plen) ? '0 : r_ptr;
        slot_inc = LEN_W'(slot) + LEN_W'(1);
        win_full = (r_seen >= r_plen);
        seen_new = win_full ? r_seen : r_seen + LEN_W'(1);

        enter_op           = '0;
        enter_op.code      = i_char_code;
        enter_op.dec       = 1'b1;
        enter_op.check     = (seen_new >= r_plen);

        n_pend    = r_pend;
        n_pend_op = r_pend_op;
        n_plen    = r_plen;
        n_ptr     = r_ptr;
        n_seen    = r_seen;
        n_ovf     = r_ovf;
        n_started = r_started;
        ring_we   = 1'b0;
        o_op_push = 1'b0;
        o_op      = '0;

        if (r_pend && !i_qstat.full) begin
            o_op_push = 1'b1;
            o_op      = r_pend_op;
            n_pend    = 1'b0;
        end

        if (accept) begin
            case (i_req_type)
                REQ_PATTERN: begin
                    if (!r_started) begin
                        if (r_ovf || (r_plen >= LEN_W'(PATTERN_MAX))) begin
                            n_ovf = 1'b1;
                        end else begin
                            o_op_push = 1'b1;
                            o_op.code = i_char_code;
                            n_plen    = r_plen + LEN_W'(1);
                        end
                    end
                end
                REQ_TEXT: begin
                    n_started = 1'b1;
                    if (!r_ovf && (r_plen != '0)) begin
                        o_op_push = 1'b1;
                        if (win_full) begin
                            o_op.code = r_ring[slot];
                            n_pend    = 1'b1;
                            n_pend_op = enter_op;
                        end else begin
                            o_op = enter_op;
                        end
                        ring_we = 1'b1;
                        n_ptr   = (slot_inc >= r_plen) ? '0 : PTR_W'(slot_inc);
                        n_seen  = seen_new;
                    end
                end
                REQ_FINISH: begin
                    o_op_push      = 1'b1;
                    o_op.is_report = 1'b1;
                    o_op.rep_ovf   = r_ovf;
                    o_op.rep_empty = (r_plen == '0);
                    n_plen         = '0;
                    n_ptr          = '0;
                    n_seen         = '0;
                    n_ovf          = 1'b0;
                    n_started      = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_plen    <= '0;
            r_ptr     <= '0;
            r_seen    <= '0;
            r_ovf     <= 1'b0;
            r_started <= 1'b0;
        end else begin
            r_pend    <= n_pend;
            r_plen    <= n_plen;
            r_ptr     <= n_ptr;
            r_seen    <= n_seen;
            r_ovf     <= n_ovf;
            r_started <= n_started;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_op <= n_pend_op;
        if (ring_we) begin
            r_ring[slot] <= i_char_code;
        end
    end

endmodule

// ===== hw/rtl/awsu_opq.sv =====
// Short operation queue between the front end and the back end.
module awsu_opq import awsu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_op    i_op,
    input  logic   i_pop,
    output t_op    o_head,
    output t_qstat o_qstat
);

    t_op             r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_cnt;

    logic            do_push;
    logic            do_pop;

    assign o_qstat.full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + Q_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + Q_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (Q_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (Q_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

// ===== hw/rtl/awsu_back.sv =====
// Back end: read-modify-write of the difference table, nonzero tracking and the result register.
module awsu_back import awsu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_op    i_op,
    input  t_qstat i_qstat,
    output logic   o_op_pop,
    output logic   o_empty,
    input  logic   i_pop,
    output logic   o_found,
    output logic   o_pattern_overflow
);

    logic                 r_b_valid;
    t_op                  r_b_op;
    logic [TBL_DEPTH-1:0] r_valid;
    logic                 r_fwd_en;
    logic [CODE_W-1:0]    r_fwd_addr;
    logic [CNT_W-1:0]     r_fwd_data;
    logic [NZ_W-1:0]      r_nz;
    logic                 r_match;
    logic                 r_out_valid;
    logic                 r_found;
    logic                 r_ovf;

    logic [NZ_W-1:0]      n_nz;
    logic                 n_match;
    logic                 n_out_valid;

    logic                 a_go;
    logic                 b_done;
    logic                 b_adj;
    logic                 b_rep;
    logic [CNT_W-1:0]     ram_rdata;
    logic [CNT_W-1:0]     cur;
    logic [CNT_W-1:0]     upd;

    assign b_done   = r_b_valid && (!r_b_op.is_report || !r_out_valid || i_pop);
    assign a_go     = !i_qstat.empty && (!r_b_valid || b_done);
    assign o_op_pop = a_go;
    assign b_adj    = r_b_valid && !r_b_op.is_report;
    assign b_rep    = r_b_valid && r_b_op.is_report && b_done;

    awsu_ram #(
        .WIDTH(CNT_W),
        .DEPTH(TBL_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (b_adj),
        .i_waddr(r_b_op.code),
        .i_wdata(upd),
        .i_re   (a_go),
        .i_raddr(i_op.code),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        if (!r_valid[r_b_op.code]) begin
            cur = '0;
        end else if (r_fwd_en && (r_fwd_addr == r_b_op.code)) begin
            cur = r_fwd_data;
        end else begin
            cur = ram_rdata;
        end
        upd = cur + (r_b_op.dec ? {CNT_W{1'b1}} : CNT_W'(1));

        n_nz    = r_nz;
        n_match = r_match;
        if (b_adj) begin
            if (cur == '0) begin
                n_nz = r_nz + NZ_W'(1);
            end else if (upd == '0) begin
                n_nz = r_nz - NZ_W'(1);
            end
            if (r_b_op.check && (n_nz == '0)) begin
                n_match = 1'b1;
            end
        end

        n_out_valid = r_out_valid && !i_pop;
        if (b_rep) begin
            n_out_valid = 1'b1;
            n_nz        = '0;
            n_match     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_valid     <= '0;
            r_fwd_en    <= 1'b0;
            r_nz        <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_go) begin
                r_b_valid <= 1'b1;
            end else if (b_done) begin
                r_b_valid <= 1'b0;
            end
            if (b_rep) begin
                r_valid <= '0;
            end else if (b_adj) begin
                r_valid[r_b_op.code] <= 1'b1;
            end
            r_fwd_en    <= b_adj;
            r_nz        <= n_nz;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_b_op <= i_op;
        end
        r_fwd_addr <= r_b_op.code;
        r_fwd_data <= upd;
        if (b_rep) begin
            r_found <= !r_b_op.rep_ovf && (r_b_op.rep_empty || r_match);
            r_ovf   <= r_b_op.rep_ovf;
        end
    end

    assign o_empty            = !r_out_valid;
    assign o_found            = r_found;
    assign o_pattern_overflow = r_ovf;

endmodule

// ===== hw/rtl/anagram_window_search_unit.sv =====
// Top level of the anagram window search unit: front end, operation queue and back end.
//
//   Channel   Direction  Handshake        Payload
//   request   in         i_push / o_full  i_req_type, i_char_code
//   result    out        o_empty / i_pop  o_found, o_pattern_overflow
//
// A pattern byte costs one table operation and a text byte two once the window is full,
// so the front end waits until the second is queued; at most one table update per cycle.
// The back end reads the table one cycle and writes it the next, overlapped across operations.
// A result follows its finish through the queue and back end, waiting behind earlier work.
// Reset clears all control state and the table valid bits at once; no clearing pass is needed.
// A waiting result stalls only the back end; requests keep arriving until the queue fills.
`include "anagram_window_search_unit_defines.svh"

module anagram_window_search_unit import awsu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [1:0]        i_req_type,
    input  logic [CODE_W-1:0] i_char_code,
    output logic              o_empty,
    input  logic              i_pop,
    output logic              o_found,
    output logic              o_pattern_overflow
);

    logic   q_push;
    logic   q_pop;
    t_op    q_in;
    t_op    q_head;
    t_qstat q_stat;

    awsu_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .o_full     (o_full),
        .i_req_type (i_req_type),
        .i_char_code(i_char_code),
        .o_op_push  (q_push),
        .o_op       (q_in),
        .i_qstat    (q_stat)
    );

    awsu_opq u_opq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_op   (q_in),
        .i_pop  (q_pop),
        .o_head (q_head),
        .o_qstat(q_stat)
    );

    awsu_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_op              (q_head),
        .i_qstat           (q_stat),
        .o_op_pop          (q_pop),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_found           (o_found),
        .o_pattern_overflow(o_pattern_overflow)
    );

    `AWSU_ASSERT_NOW(a_queue_no_overrun, q_push, !q_stat.full, "operation pushed into a full queue")
    `AWSU_ASSERT_NOW(a_queue_no_underrun, q_pop, !q_stat.empty, "operation taken from an empty queue")
    `AWSU_ASSERT_NOW(a_overflow_not_found, !o_empty && o_pattern_overflow, !o_found, "match reported with overflow")

endmodule
